// ----- src/slcd_pkg.sv -----
// Shared types, codes and constant tables of the segment LCD character writer.
package slcd_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_CHAR    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_FILL    = 2'd2,
    OP_STARTUP = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_POS_ERR  = 2'd1,
    ST_CHAR_ERR = 2'd2
  } status_e;

  // Work kinds handed from the front to the back
  typedef enum logic [1:0] {
    JOB_CHAR  = 2'd0,
    JOB_SWEEP = 2'd1,
    JOB_START = 2'd2,
    JOB_ERROR = 2'd3
  } job_kind_e;

  localparam int unsigned CHIP_COUNT  = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FRAME_W     = 13;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned BITS_W      = 4;
  localparam int unsigned GLYPH_W     = 4 * NIB_W;

  localparam logic [2:0]        DATA_HEADER = 3'b101;
  localparam logic [NIB_W-1:0]  CLEAR_NIB   = 4'h0;
  localparam logic [NIB_W-1:0]  FILL_NIB    = 4'hF;
  localparam logic [BITS_W-1:0] DATA_BITS   = 4'd13;
  localparam logic [BITS_W-1:0] CMD_BITS    = 4'd12;
  localparam logic [BITS_W-1:0] NO_BITS     = 4'd0;

  // One classified request
  typedef struct packed {
    job_kind_e            kind;
    status_e              status;
    logic                 chip;
    logic [ADDR_W-1:0]    base_addr;
    logic [GLYPH_W-1:0]   glyph;
    logic [NIB_W-1:0]     sweep_nib;
  } job_t;

  // Controller start-up commands, sent to each chip in this order
  localparam logic [11:0] STARTUP_CMD [4] = '{12'h830, 12'h802, 12'h806, 12'h852};

  // 15-segment font; byte i holds the nibble for the cell's address i
  localparam logic [31:0] FONT_ROM [128] = '{
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000C00, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000400,
    32'h00000000, 32'h00000000, 32'h00070806, 32'h00020604,
    32'h00000002, 32'h00020004, 32'h01000000, 32'h00040002,
    32'h06080109, 32'h00000009, 32'h040A0105, 32'h060A0104,
    32'h0602000C, 32'h020A010C, 32'h020A010D, 32'h06080000,
    32'h060A010D, 32'h060A010C, 32'h00000600, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h060A000D, 32'h060A010D, 32'h00080109,
    32'h06080700, 32'h000A010D, 32'h000A000D, 32'h020A0109,
    32'h0602000D, 32'h00080700, 32'h00090500, 32'h0005000D,
    32'h00000109, 32'h06040A09, 32'h06010809, 32'h06080109,
    32'h040A000D, 32'h06090109, 32'h040B000D, 32'h020A010C,
    32'h00080600, 32'h06000109, 32'h0004000B, 32'h0601040B,
    32'h00050802, 32'h00040A00, 32'h000C0102, 32'h00080109,
    32'h00010800, 32'h06080100, 32'h00000000, 32'h00000100,
    32'h00000000, 32'h00000000, 32'h0202010D, 32'h00020105,
    32'h06020105, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h0202000D, 32'h00000000, 32'h00000000, 32'h00050600,
    32'h00000000, 32'h02020205, 32'h02020005, 32'h02020105,
    32'h00000000, 32'h00000000, 32'h00000005, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00050802, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000600, 32'h00000000, 32'h00000000, 32'h00000000
  };

endpackage

// ----- src/slcd_if.sv -----
// Request and result channel interfaces of the segment LCD character writer.
interface slcd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] position;
  logic [7:0] char_code;
  logic       with_dot;

  modport source (output valid, output opcode, output position, output char_code,
                  output with_dot, input ready);
  modport sink   (input valid, input opcode, input position, input char_code,
                  input with_dot, output ready);
endinterface

interface slcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        chip_select;
  logic [12:0] frame;
  logic [3:0]  bit_count;
  logic        last;

  modport source (output valid, output status, output chip_select, output frame,
                  output bit_count, output last, input ready);
  modport sink   (input valid, input status, input chip_select, input frame,
                  input bit_count, input last, output ready);
endinterface

// ----- src/segment_lcd_char_writer.sv -----
// Top level of the segment LCD character writer.
// Each request becomes a run of serial write frames for two segment LCD controller chips,
// one result per cycle while the result side keeps taking them: a character gives four
// 13-bit data frames, clear or fill 2*SEGMENT_ADDRS data frames, the start-up commands
// four 12-bit commands per chip, and a bad position or a code of 128 or more a single
// error result. The back-end frame sequencer emits one frame per cycle while the result
// side takes them; the front end takes a new request in any cycle in which its two-entry
// queue has room, so requests overlap the frames of earlier ones. The last result of
// every request carries last.
module segment_lcd_char_writer #(
  parameter int unsigned CHARS_PER_CHIP = 8,
  parameter int unsigned SEGMENT_ADDRS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slcd_req_if.sink   req_i,
  slcd_rsp_if.source rsp_o
);

  slcd_pkg::job_t front_job;
  logic           front_valid;
  logic           front_ready;
  slcd_pkg::job_t head_job;
  logic           head_valid;
  logic           pop;

  slcd_front #(
    .CHARS_PER_CHIP (CHARS_PER_CHIP)
  ) u_front (
    .req_i       (req_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  slcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (head_job),
    .pop_valid_o  (head_valid),
    .pop_i        (pop)
  );

  slcd_back #(
    .SEGMENT_ADDRS (SEGMENT_ADDRS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .pop_o       (pop),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTHESIS
  // A request leaves the queue only when one is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("queue popped while empty");

  // An error result is a lone, empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != slcd_pkg::ST_OK) |->
      (rsp_o.last && rsp_o.bit_count == slcd_pkg::NO_BITS && rsp_o.frame == '0))
    else $error("malformed error result");

  // Data frames carry the write header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.bit_count == slcd_pkg::DATA_BITS) |->
      (rsp_o.frame[12:10] == slcd_pkg::DATA_HEADER))
    else $error("data frame without write header");
`endif

endmodule

// ----- src/slcd_front.sv -----
// Front end: accepts a request, checks it and looks up the glyph.
module slcd_front #(
  parameter int unsigned CHARS_PER_CHIP = 8
) (
  slcd_req_if.sink       req_i,
  output slcd_pkg::job_t job_o,
  output logic           job_valid_o,
  input  logic           job_ready_i
);

  localparam logic [5:0] CellsPerChip = 6'(CHARS_PER_CHIP);
  localparam logic [5:0] CellCount    = 6'(CHARS_PER_CHIP * slcd_pkg::CHIP_COUNT);

  logic [5:0]  pos_ext;
  logic [5:0]  cell_idx;
  logic [5:0]  chip_cell;
  logic        on_second;
  logic        pos_bad;
  logic [31:0] rom_word;

  // Pass the handshake through to the queue
  assign job_valid_o = req_i.valid;
  assign req_i.ready = job_ready_i;

  // Split the 1-based cell number into chip and cell within the chip
  always_comb begin
    pos_ext   = {1'b0, req_i.position};
    cell_idx  = pos_ext - 6'd1;
    pos_bad   = (pos_ext == 6'd0) || (pos_ext > CellCount);
    on_second = (cell_idx >= CellsPerChip);
    chip_cell = on_second ? (cell_idx - CellsPerChip) : cell_idx;
    rom_word  = slcd_pkg::FONT_ROM[req_i.char_code[6:0]];
  end

  // Classify the request
  always_comb begin
    job_o           = '0;
    job_o.kind      = slcd_pkg::JOB_ERROR;
    job_o.status    = slcd_pkg::ST_OK;
    job_o.sweep_nib = slcd_pkg::CLEAR_NIB;
    unique case (slcd_pkg::op_e'(req_i.opcode))
      slcd_pkg::OP_CLEAR: begin
        job_o.kind = slcd_pkg::JOB_SWEEP;
      end
      slcd_pkg::OP_FILL: begin
        job_o.kind      = slcd_pkg::JOB_SWEEP;
        job_o.sweep_nib = slcd_pkg::FILL_NIB;
      end
      slcd_pkg::OP_STARTUP: begin
        job_o.kind = slcd_pkg::JOB_START;
      end
      default: begin
        if (pos_bad) begin
          job_o.status = slcd_pkg::ST_POS_ERR;
        end else if (req_i.char_code[7]) begin
          job_o.status = slcd_pkg::ST_CHAR_ERR;
        end else begin
          job_o.kind      = slcd_pkg::JOB_CHAR;
          job_o.chip      = on_second;
          job_o.base_addr = {chip_cell[3:0], 2'b00};
          job_o.glyph     = {rom_word[27:25], rom_word[24] | req_i.with_dot,
                             rom_word[19:16], rom_word[11:8], rom_word[3:0]};
        end
      end
    endcase
  end

endmodule

// ----- src/slcd_queue.sv -----
// Short queue of classified requests between the front and the back end.
module slcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slcd_pkg::job_t push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output slcd_pkg::job_t pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = $clog2(slcd_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(slcd_pkg::QUEUE_DEPTH + 1);

  slcd_pkg::job_t entries_q [slcd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  assign push_ready_o = (count_q != CntW'(slcd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/slcd_back.sv -----
// Back end: steps through a request's frames and holds them in the output register.
module slcd_back #(
  parameter int unsigned SEGMENT_ADDRS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slcd_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           pop_o,
  slcd_rsp_if.source     rsp_o
);

  localparam int unsigned AddrCntW = (SEGMENT_ADDRS > 1) ? $clog2(SEGMENT_ADDRS) : 1;
  localparam int unsigned StepW    = (AddrCntW > 2) ? AddrCntW : 2;
  localparam logic [StepW-1:0] SweepEnd = StepW'(SEGMENT_ADDRS - 1);
  localparam logic [StepW-1:0] QuadEnd  = StepW'(3);

  logic [StepW-1:0] step_q, step_d;
  logic             chip_q, chip_d;

  logic                              out_valid_q;
  logic [1:0]                        status_q, status_d;
  logic                              chip_sel_q, chip_sel_d;
  logic [slcd_pkg::FRAME_W-1:0]      frame_q, frame_d;
  logic [slcd_pkg::BITS_W-1:0]       bits_q, bits_d;
  logic                              last_q, last_d;

  logic                              load;
  logic                              seg_end;
  logic [slcd_pkg::ADDR_W-1:0]       addr;
  logic [slcd_pkg::NIB_W-1:0]        nib;

  assign load  = job_valid_i && (!out_valid_q || rsp_o.ready);
  assign pop_o = load && last_d;

  // Build the frame for the current step
  always_comb begin
    status_d   = slcd_pkg::ST_OK;
    chip_sel_d = chip_q;
    addr       = '0;
    nib        = '0;
    frame_d    = '0;
    bits_d     = slcd_pkg::DATA_BITS;
    seg_end    = 1'b0;
    last_d     = 1'b0;
    unique case (job_i.kind)
      slcd_pkg::JOB_CHAR: begin
        chip_sel_d = job_i.chip;
        addr       = job_i.base_addr + slcd_pkg::ADDR_W'(step_q[1:0]);
        nib        = job_i.glyph[{step_q[1:0], 2'b00} +: slcd_pkg::NIB_W];
        frame_d    = {slcd_pkg::DATA_HEADER, addr, nib};
        seg_end    = (step_q == QuadEnd);
        last_d     = seg_end;
      end
      slcd_pkg::JOB_SWEEP: begin
        addr    = slcd_pkg::ADDR_W'(step_q);
        nib     = job_i.sweep_nib;
        frame_d = {slcd_pkg::DATA_HEADER, addr, nib};
        seg_end = (step_q == SweepEnd);
        last_d  = seg_end && chip_q;
      end
      slcd_pkg::JOB_START: begin
        frame_d = {1'b0, slcd_pkg::STARTUP_CMD[step_q[1:0]]};
        bits_d  = slcd_pkg::CMD_BITS;
        seg_end = (step_q == QuadEnd);
        last_d  = seg_end && chip_q;
      end
      default: begin
        status_d   = job_i.status;
        chip_sel_d = 1'b0;
        bits_d     = slcd_pkg::NO_BITS;
        seg_end    = 1'b1;
        last_d     = 1'b1;
      end
    endcase
  end

  // Advance the step and chip counters
  always_comb begin
    step_d = step_q;
    chip_d = chip_q;
    if (load) begin
      if (last_d) begin
        step_d = '0;
        chip_d = 1'b0;
      end else if (seg_end) begin
        step_d = '0;
        chip_d = 1'b1;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      chip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      chip_q <= chip_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the frame until it is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q   <= status_d;
      chip_sel_q <= chip_sel_d;
      frame_q    <= frame_d;
      bits_q     <= bits_d;
      last_q     <= last_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.chip_select = chip_sel_q;
  assign rsp_o.frame       = frame_q;
  assign rsp_o.bit_count   = bits_q;
  assign rsp_o.last        = last_q;

endmodule

// ----- bench/tb_segment_lcd_char_writer.sv -----
// Testbench of segment_lcd_char_writer: directed and random requests checked frame by frame.
`timescale 1ns / 100ps

module tb_segment_lcd_char_writer;

  localparam int unsigned CHARS_PER_CHIP = 8;
  localparam int unsigned SEGMENT_ADDRS  = 32;
  localparam int unsigned RANDOM_REQS    = 452;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT    = 4_000_000;
  localparam int unsigned SCRIPT_LEN     = 19;

  // One request as offered on the input channel
  typedef struct packed {
    slcd_pkg::op_e op;
    logic [4:0]    pos;
    logic [7:0]    code;
    logic          dot;
  } lcd_req_t;

  // One frame as produced on the result channel
  typedef struct packed {
    slcd_pkg::status_e status;
    logic              chip;
    logic [12:0]       frame;
    logic [3:0]        bits;
    logic              last;
  } lcd_frame_t;

  // Directed row: the request, and a typed-in result where one is given
  typedef struct packed {
    lcd_req_t   req;
    logic       typed;
    lcd_frame_t want;
  } script_row_t;

  localparam lcd_frame_t POS_FAULT  =
    '{slcd_pkg::ST_POS_ERR, 1'b0, 13'd0, slcd_pkg::NO_BITS, 1'b1};
  localparam lcd_frame_t CHAR_FAULT =
    '{slcd_pkg::ST_CHAR_ERR, 1'b0, 13'd0, slcd_pkg::NO_BITS, 1'b1};

  logic clk;
  logic rst_n;

  slcd_req_if req_bus ();
  slcd_rsp_if rsp_bus ();

  segment_lcd_char_writer #(
    .CHARS_PER_CHIP(CHARS_PER_CHIP),
    .SEGMENT_ADDRS (SEGMENT_ADDRS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  lcd_frame_t frames_due[$];
  int unsigned fault_count = 0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;

  // Extremes, every opcode, both error kinds, font gaps and the dot on a lit bit
  script_row_t script [SCRIPT_LEN] = '{
    '{'{slcd_pkg::OP_STARTUP, 5'd31, 8'hFF, 1'b1}, 1'b0, '0},
    '{'{slcd_pkg::OP_CLEAR,   5'd0,  8'h00, 1'b0}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd1,  8'h30, 1'b0}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd16, 8'h7F, 1'b1}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd8,  8'h41, 1'b1}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd9,  8'h00, 1'b0}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd0,  8'h41, 1'b0}, 1'b1, POS_FAULT},
    '{'{slcd_pkg::OP_CHAR,    5'd17, 8'h41, 1'b0}, 1'b1, POS_FAULT},
    '{'{slcd_pkg::OP_CHAR,    5'd31, 8'hFF, 1'b1}, 1'b1, POS_FAULT},
    '{'{slcd_pkg::OP_CHAR,    5'd0,  8'h80, 1'b0}, 1'b1, POS_FAULT},
    '{'{slcd_pkg::OP_CHAR,    5'd5,  8'h80, 1'b0}, 1'b1, CHAR_FAULT},
    '{'{slcd_pkg::OP_CHAR,    5'd12, 8'hFF, 1'b1}, 1'b1, CHAR_FAULT},
    '{'{slcd_pkg::OP_FILL,    5'd0,  8'h00, 1'b0}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd4,  8'h38, 1'b1}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd13, 8'h31, 1'b1}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd7,  8'h2E, 1'b1}, 1'b0, '0},
    '{'{slcd_pkg::OP_CHAR,    5'd10, 8'h41, 1'b0}, 1'b0, '0},
    '{'{slcd_pkg::OP_STARTUP, 5'd0,  8'h00, 1'b0}, 1'b0, '0},
    '{'{slcd_pkg::OP_CLEAR,   5'd31, 8'hFF, 1'b1}, 1'b0, '0}
  };

  // Build the 13-bit data frame for one nibble address
  function automatic logic [12:0] data_word(input logic [5:0] addr, input logic [3:0] nib);
    return {slcd_pkg::DATA_HEADER, addr, nib};
  endfunction

  // Queue the frames that one accepted request must produce
  function automatic void predict_frames(input lcd_req_t r);
    logic [3:0]  nib;
    logic [5:0]  base;
    logic [31:0] glyph;
    logic        chip;
    case (r.op) inside
      slcd_pkg::OP_CLEAR, slcd_pkg::OP_FILL: begin
        nib = (r.op == slcd_pkg::OP_FILL) ? slcd_pkg::FILL_NIB : slcd_pkg::CLEAR_NIB;
        for (int c = 0; c < slcd_pkg::CHIP_COUNT; c++) begin
          for (int a = 0; a < SEGMENT_ADDRS; a++) begin
            frames_due.push_back(lcd_frame_t'{slcd_pkg::ST_OK, c[0],
                                 data_word(a[5:0], nib), slcd_pkg::DATA_BITS,
                                 (c == slcd_pkg::CHIP_COUNT - 1) &&
                                 (a == SEGMENT_ADDRS - 1)});
          end
        end
      end
      slcd_pkg::OP_STARTUP: begin
        for (int c = 0; c < slcd_pkg::CHIP_COUNT; c++) begin
          for (int i = 0; i < 4; i++) begin
            frames_due.push_back(lcd_frame_t'{slcd_pkg::ST_OK, c[0],
                                 {1'b0, slcd_pkg::STARTUP_CMD[i]}, slcd_pkg::CMD_BITS,
                                 (c == slcd_pkg::CHIP_COUNT - 1) && (i == 3)});
          end
        end
      end
      default: begin
        if (r.pos == 0 || r.pos > CHARS_PER_CHIP * slcd_pkg::CHIP_COUNT) begin
          frames_due.push_back(POS_FAULT);
        end else if (r.code[7]) begin
          frames_due.push_back(CHAR_FAULT);
        end else begin
          chip  = (r.pos > CHARS_PER_CHIP);
          base  = 6'(4 * ((r.pos - 1) % CHARS_PER_CHIP));
          glyph = slcd_pkg::FONT_ROM[r.code[6:0]];
          for (int i = 0; i < 4; i++) begin
            nib = glyph[8*i +: 4];
            if (i == 3 && r.dot) nib[0] = 1'b1;
            frames_due.push_back(lcd_frame_t'{slcd_pkg::ST_OK, chip,
                                 data_word(base + 6'(i), nib), slcd_pkg::DATA_BITS,
                                 i == 3});
          end
        end
      end
    endcase
  endfunction

  // Compare one accepted result against the oldest expectation
  function automatic void check_frame();
    lcd_frame_t want;
    if (frames_due.size() == 0) begin
      fault_count++;
      $display("%0t: unexpected result, expected none, %s", $time,
               $sformatf("actual status=%0d chip=%0b frame=%h bits=%0d last=%0b",
                         rsp_bus.status, rsp_bus.chip_select, rsp_bus.frame,
                         rsp_bus.bit_count, rsp_bus.last));
      return;
    end
    want = frames_due.pop_front();
    if (rsp_bus.status !== want.status || rsp_bus.chip_select !== want.chip ||
        rsp_bus.frame !== want.frame || rsp_bus.bit_count !== want.bits ||
        rsp_bus.last !== want.last) begin
      fault_count++;
      $display("%0t: mismatch expected status=%0d chip=%0b frame=%h bits=%0d last=%0b, %s",
               $time, want.status, want.chip, want.frame, want.bits, want.last,
               $sformatf("actual status=%0d chip=%0b frame=%h bits=%0d last=%0b",
                         rsp_bus.status, rsp_bus.chip_select, rsp_bus.frame,
                         rsp_bus.bit_count, rsp_bus.last));
    end
  endfunction

  // Draw a random request: mostly valid characters, some sweeps, start-ups and bad fields
  function automatic lcd_req_t random_req();
    lcd_req_t r;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 86)      r.op = slcd_pkg::OP_CHAR;
    else if (k < 90) r.op = slcd_pkg::OP_CLEAR;
    else if (k < 94) r.op = slcd_pkg::OP_FILL;
    else             r.op = slcd_pkg::OP_STARTUP;
    r.pos  = ($urandom_range(99) < 88) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(31));
    r.code = ($urandom_range(99) < 90) ? 8'($urandom_range(127)) : 8'($urandom_range(128, 255));
    r.dot  = 1'($urandom_range(1));
    return r;
  endfunction

  // Idle length before a request: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned k;
    if (calm) return 0;
    k = $urandom_range(99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Offer one request after a gap; hold it until it is taken
  task automatic drive_req(input lcd_req_t r, input int unsigned gap, input logic typed,
                           input lcd_frame_t want);
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) begin
        req_bus.opcode    = 2'($urandom_range(3));
        req_bus.position  = 5'($urandom_range(31));
        req_bus.char_code = 8'($urandom_range(255));
        req_bus.with_dot  = 1'($urandom_range(1));
        @(negedge clk);
      end
    end
    req_bus.valid     = 1'b1;
    req_bus.opcode    = r.op;
    req_bus.position  = r.pos;
    req_bus.char_code = r.code;
    req_bus.with_dot  = r.dot;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    if (typed) frames_due.push_back(want);
    else       predict_frames(r);
    @(negedge clk);
  endtask

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset low at start, release it on a falling edge
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Result side: random stalls, one long hold-off on request, none while calm
  initial begin
    int unsigned stall_left;
    int unsigned k;
    stall_left    = 0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req      = 1'b0;
        rsp_bus.ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        rsp_bus.ready = 1'b1;
      end else if (calm) begin
        rsp_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready = 1'b0;
      end else begin
        k = $urandom_range(99);
        if (k < 65) begin
          rsp_bus.ready = 1'b1;
        end else if (k < 95) begin
          rsp_bus.ready = 1'b0;
          stall_left    = $urandom_range(2);
        end else begin
          rsp_bus.ready = 1'b0;
          stall_left    = $urandom_range(8, 24);
        end
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_frame();
  end

  // Abort a hung run
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus: directed script, then random requests with pressure phases
  initial begin
    req_bus.valid     = 1'b0;
    req_bus.opcode    = slcd_pkg::OP_CHAR;
    req_bus.position  = 5'd0;
    req_bus.char_code = 8'd0;
    req_bus.with_dot  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      drive_req(script[i].req, pick_gap(), script[i].typed, script[i].want);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      // Fill the block while results are held off
      if (i == 120) hold_req = 1'b1;
      // Run a stretch with no idling on either side
      calm = (i >= 200 && i < 260);
      // Pause until every expected frame has drained
      if (i == 320) begin
        req_bus.valid = 1'b0;
        while (frames_due.size() != 0) @(negedge clk);
      end
      drive_req(random_req(), pick_gap(), 1'b0, '0);
    end
    req_bus.valid = 1'b0;

    // Drain, then watch for stray results
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
